// ----- rtl/tshf_pkg.sv -----
`timescale 1ns / 1ps

package tshf_pkg;

  // Operating modes of the flasher. Code 3 is unused and decodes as idle.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ON   = 2'd1,
    MODE_OFF  = 2'd2
  } mode_t;

  // Configuration register indexes.
  localparam logic [7:0] CFG_HALF_PERIOD   = 8'd0;
  localparam logic [7:0] CFG_COMFORT_LIMIT = 8'd1;

  localparam logic [15:0] HALF_PERIOD_RESET   = 16'd500;
  localparam logic [7:0]  COMFORT_LIMIT_RESET = 8'd5;

  localparam int COUNT_BITS_DEFAULT = 16;

  // Lamp bit order: front left, rear left, front right, rear right.
  function automatic logic [3:0] side_mask(input logic side);
    return side ? 4'hC : 4'h3;
  endfunction

endpackage

// ----- rtl/turn_signal_hazard_flasher.sv -----
`timescale 1ns / 1ps

// A result beat appears in the cycle after its input beat is accepted. One
// beat is taken per cycle while the lamp side keeps taking results; the whole
// tick update is a single pass of logic from the state registers back into
// them, and the lamp register is the output register. Reset (rst, synchronous)
// returns all state to idle, lamps off, half period 500 and comfort limit 5.
module turn_signal_hazard_flasher
  import tshf_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [0] hazard_switch, [1] left_switch, [2] right_switch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [0] lamp_front_left, [1] lamp_rear_left,
                                  // [2] lamp_front_right, [3] lamp_rear_right
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Counters are compared against the 16-bit half period at the wider of the
  // two widths, so a period beyond the counter range is simply never reached.
  localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [15:0] half_period;
  logic [7:0]  comfort_limit;

  mode_t                 mode_reg, mode_reg_next;
  logic                  entry_pending, entry_pending_next;
  logic                  latched_hazard, latched_left, latched_right;
  logic [3:0]            lamp_levels, lamp_levels_next;
  logic                  active_side, active_side_next;
  logic                  carried_phase, carried_phase_next;
  logic [COUNT_BITS-1:0] carried_count, carried_count_next;
  logic [COUNT_BITS-1:0] hazard_count, hazard_count_next;
  logic                  hazard_first, hazard_first_next;
  logic                  hazard_phase, hazard_phase_next;
  logic [COUNT_BITS-1:0] side_count, side_count_next;
  logic                  side_first, side_first_next;
  logic                  side_phase, side_phase_next;
  logic [COUNT_BITS-1:0] release_count, release_count_next;
  logic                  release_side, release_side_next;
  logic                  release_phase, release_phase_next;
  logic [7:0]            toggle_cycles, toggle_cycles_next;

  logic step;
  logic comfort_active;

  // A new beat is taken whenever the output register is empty or is being
  // drained in this same cycle.
  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'b0000, lamp_levels};

  // Comfort flashing stops once the toggles plus the carried phase meet the
  // limit; the sum is nine bits wide so it never wraps onto the limit.
  assign comfort_active =
    ({1'b0, toggle_cycles} + {8'd0, carried_phase}) != {1'b0, comfort_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period   <= HALF_PERIOD_RESET;
      comfort_limit <= COMFORT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_HALF_PERIOD) begin
        half_period <= cfg_data;
      end else if (cfg_index == CFG_COMFORT_LIMIT) begin
        comfort_limit <= cfg_data[7:0];
      end
    end
  end

  // One tick of the flasher. The mode logic acts on the switch levels that
  // were latched with the previous beat; the current beat is latched after.
  always_comb begin
    mode_reg_next      = mode_reg;
    entry_pending_next = entry_pending;
    lamp_levels_next   = lamp_levels;
    active_side_next   = active_side;
    carried_phase_next = carried_phase;
    carried_count_next = carried_count;
    hazard_count_next  = hazard_count;
    hazard_first_next  = hazard_first;
    hazard_phase_next  = hazard_phase;
    side_count_next    = side_count;
    side_first_next    = side_first;
    side_phase_next    = side_phase;
    release_count_next = release_count;
    release_side_next  = release_side;
    release_phase_next = release_phase;
    toggle_cycles_next = toggle_cycles;

    unique case (mode_reg)
      MODE_ON: begin
        // The side is sampled only on entry and the count resumes from the
        // value carried out of comfort mode.
        if (entry_pending) begin
          active_side_next   = latched_right;
          entry_pending_next = 1'b0;
          side_count_next    = carried_count;
        end
        if (side_first) begin
          lamp_levels_next = lamp_levels_next | side_mask(active_side_next);
          side_first_next  = 1'b0;
        end
        if (CMP_BITS'(side_count_next) == CMP_BITS'(half_period)) begin
          if (side_phase) begin
            lamp_levels_next = lamp_levels_next | side_mask(active_side_next);
          end else begin
            lamp_levels_next = lamp_levels_next & ~side_mask(active_side_next);
          end
          side_phase_next = !side_phase;
          side_count_next = '0;
        end else begin
          side_count_next = side_count_next + 1'b1;
        end
        if (latched_hazard) begin
          mode_reg_next      = MODE_IDLE;
          entry_pending_next = 1'b1;
          side_count_next    = '0;
          side_phase_next    = 1'b0;
          side_first_next    = 1'b1;
          lamp_levels_next   = 4'h0;
        end else if (!latched_left && !latched_right) begin
          mode_reg_next      = MODE_OFF;
          entry_pending_next = 1'b1;
          carried_phase_next = side_phase_next;
          carried_count_next = side_count_next;
          side_count_next    = '0;
          side_phase_next    = 1'b0;
          side_first_next    = 1'b1;
        end
      end

      MODE_OFF: begin
        if (entry_pending) begin
          entry_pending_next = 1'b0;
          release_phase_next = carried_phase;
          release_side_next  = active_side;
          release_count_next = carried_count;
        end
        if (comfort_active) begin
          if (CMP_BITS'(release_count_next) == CMP_BITS'(half_period)) begin
            if (release_phase_next) begin
              lamp_levels_next = lamp_levels_next | side_mask(release_side_next);
            end else begin
              lamp_levels_next = lamp_levels_next & ~side_mask(release_side_next);
            end
            release_phase_next = !release_phase_next;
            toggle_cycles_next = toggle_cycles + 8'd1;
            release_count_next = '0;
          end else begin
            release_count_next = release_count_next + 1'b1;
          end
        end
        if (latched_hazard || latched_left || latched_right) begin
          mode_reg_next      = latched_hazard ? MODE_IDLE : MODE_ON;
          entry_pending_next = 1'b1;
          carried_count_next = release_count_next;
          toggle_cycles_next = 8'd0;
          release_count_next = '0;
        end
      end

      default: begin
        // Idle and hazard flashing; the unused mode code lands here as well.
        if (entry_pending) begin
          lamp_levels_next   = 4'h0;
          entry_pending_next = 1'b0;
        end
        if (latched_hazard) begin
          if (hazard_first) begin
            lamp_levels_next  = 4'hF;
            hazard_first_next = 1'b0;
          end
          if (CMP_BITS'(hazard_count) == CMP_BITS'(half_period)) begin
            lamp_levels_next  = {4{hazard_phase}};
            hazard_phase_next = !hazard_phase;
            hazard_count_next = '0;
          end else begin
            hazard_count_next = hazard_count + 1'b1;
          end
        end else begin
          lamp_levels_next  = 4'h0;
          hazard_count_next = '0;
          hazard_first_next = 1'b1;
          hazard_phase_next = 1'b0;
        end
        if ((latched_left || latched_right) && !latched_hazard) begin
          mode_reg_next      = MODE_ON;
          entry_pending_next = 1'b1;
          hazard_count_next  = '0;
          hazard_phase_next  = 1'b0;
          lamp_levels_next   = 4'h0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_IDLE;
      entry_pending  <= 1'b1;
      latched_hazard <= 1'b0;
      latched_left   <= 1'b0;
      latched_right  <= 1'b0;
      lamp_levels    <= 4'h0;
      active_side    <= 1'b0;
      carried_phase  <= 1'b0;
      carried_count  <= '0;
      hazard_count   <= '0;
      hazard_first   <= 1'b1;
      hazard_phase   <= 1'b0;
      side_count     <= '0;
      side_first     <= 1'b1;
      side_phase     <= 1'b0;
      release_count  <= '0;
      release_side   <= 1'b0;
      release_phase  <= 1'b0;
      toggle_cycles  <= 8'd0;
    end else if (step) begin
      mode_reg       <= mode_reg_next;
      entry_pending  <= entry_pending_next;
      latched_hazard <= s_tdata[0];
      latched_left   <= s_tdata[1];
      latched_right  <= s_tdata[2];
      lamp_levels    <= lamp_levels_next;
      active_side    <= active_side_next;
      carried_phase  <= carried_phase_next;
      carried_count  <= carried_count_next;
      hazard_count   <= hazard_count_next;
      hazard_first   <= hazard_first_next;
      hazard_phase   <= hazard_phase_next;
      side_count     <= side_count_next;
      side_first     <= side_first_next;
      side_phase     <= side_phase_next;
      release_count  <= release_count_next;
      release_side   <= release_side_next;
      release_phase  <= release_phase_next;
      toggle_cycles  <= toggle_cycles_next;
    end
  end

  // The output beat is valid from the cycle after a tick until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // An empty output register never holds off the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output register is empty");

  // Every accepted tick produces a result beat in the next cycle.
  a_beat_follows_tick: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("accepted tick produced no result beat");

  // The lamps only change on an accepted tick.
  a_lamps_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(lamp_levels))
    else $error("lamp levels changed without an accepted tick");

endmodule

// ----- bench/flasher_lamp_checker.sv -----
`timescale 1ns / 1ps

module flasher_lamp_checker
  import tshf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  // Predicted lamp levels in the order the switch beats were taken.
  logic [3:0] lamp_forecast[$];

  logic [15:0] period_q;
  logic [7:0]  limit_q;

  mode_t       mode_q;
  logic        entry_q;
  logic        held_hazard, held_left, held_right;
  logic [3:0]  lamps_q;
  logic        side_q, carry_phase;
  logic [15:0] carry_count;
  logic [15:0] hazard_ticks;
  logic        hazard_fresh, hazard_level;
  logic [15:0] side_ticks;
  logic        side_fresh, side_level;
  logic [15:0] fade_ticks;
  logic        fade_side, fade_level;
  logic [7:0]  fade_toggles;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [3:0] light_side(input logic [3:0] cur, input logic level,
                                            input logic side);
    logic [3:0] group;
    group = side ? 4'b1100 : 4'b0011;
    return level ? (cur | group) : (cur & ~group);
  endfunction

  task automatic clear_flasher();
    period_q     = HALF_PERIOD_RESET;
    limit_q      = COMFORT_LIMIT_RESET;
    mode_q       = MODE_IDLE;
    entry_q      = 1'b1;
    held_hazard  = 1'b0;
    held_left    = 1'b0;
    held_right   = 1'b0;
    lamps_q      = 4'b0000;
    side_q       = 1'b0;
    carry_phase  = 1'b0;
    carry_count  = '0;
    hazard_ticks = '0;
    hazard_fresh = 1'b1;
    hazard_level = 1'b0;
    side_ticks   = '0;
    side_fresh   = 1'b1;
    side_level   = 1'b0;
    fade_ticks   = '0;
    fade_side    = 1'b0;
    fade_level   = 1'b0;
    fade_toggles = '0;
  endtask

  // One tick of the flasher. The switch levels taken here only act on the next tick.
  task automatic advance_flasher(input logic [2:0] sw, output logic [3:0] lamps);
    logic       still_on;
    logic [8:0] reach;
    case (mode_q)
      MODE_ON: begin
        if (entry_q) begin
          side_q     = held_right;
          entry_q    = 1'b0;
          side_ticks = carry_count;
        end
        if (side_fresh) begin
          lamps_q    = light_side(lamps_q, 1'b1, side_q);
          side_fresh = 1'b0;
        end
        if (side_ticks == period_q) begin
          lamps_q    = light_side(lamps_q, side_level, side_q);
          side_level = ~side_level;
          side_ticks = '0;
        end else begin
          side_ticks = side_ticks + 16'd1;
        end
        if (held_hazard) begin
          mode_q     = MODE_IDLE;
          entry_q    = 1'b1;
          side_ticks = '0;
          side_level = 1'b0;
          side_fresh = 1'b1;
          lamps_q    = 4'b0000;
        end else if (!held_left && !held_right) begin
          mode_q      = MODE_OFF;
          entry_q     = 1'b1;
          carry_phase = side_level;
          carry_count = side_ticks;
          side_ticks  = '0;
          side_level  = 1'b0;
          side_fresh  = 1'b1;
        end
      end
      MODE_OFF: begin
        if (entry_q) begin
          entry_q    = 1'b0;
          fade_level = carry_phase;
          fade_side  = side_q;
          fade_ticks = carry_count;
        end
        // Nine bits so that a zero limit with a carried phase of one is never met.
        reach    = {1'b0, fade_toggles} + {8'd0, carry_phase};
        still_on = (reach != {1'b0, limit_q});
        if (still_on && fade_ticks == period_q) begin
          lamps_q      = light_side(lamps_q, fade_level, fade_side);
          fade_level   = ~fade_level;
          fade_toggles = fade_toggles + 8'd1;
          fade_ticks   = '0;
        end else if (still_on) begin
          fade_ticks = fade_ticks + 16'd1;
        end
        if (held_hazard || held_left || held_right) begin
          mode_q       = held_hazard ? MODE_IDLE : MODE_ON;
          entry_q      = 1'b1;
          carry_count  = fade_ticks;
          fade_toggles = '0;
          fade_ticks   = '0;
        end
      end
      default: begin
        if (entry_q) begin
          lamps_q = 4'b0000;
          entry_q = 1'b0;
        end
        if (held_hazard) begin
          if (hazard_fresh) begin
            lamps_q      = 4'b1111;
            hazard_fresh = 1'b0;
          end
          if (hazard_ticks == period_q) begin
            lamps_q      = {4{hazard_level}};
            hazard_level = ~hazard_level;
            hazard_ticks = '0;
          end else begin
            hazard_ticks = hazard_ticks + 16'd1;
          end
        end else begin
          lamps_q      = 4'b0000;
          hazard_ticks = '0;
          hazard_fresh = 1'b1;
          hazard_level = 1'b0;
        end
        if ((held_left || held_right) && !held_hazard) begin
          mode_q       = MODE_ON;
          entry_q      = 1'b1;
          hazard_ticks = '0;
          hazard_level = 1'b0;
          lamps_q      = 4'b0000;
        end
      end
    endcase
    held_hazard = sw[0];
    held_left   = sw[1];
    held_right  = sw[2];
    lamps       = lamps_q;
  endtask

  task automatic check_lamp(input string lamp, input logic want, input logic got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %b, actual %b", $time, lamp, want, got);
    end
  endtask

  always @(posedge clk) begin
    logic [3:0] predicted;
    logic [3:0] want;
    if (rst) begin
      clear_flasher();
      lamp_forecast.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HALF_PERIOD)
          period_q = cfg_data;
        else if (cfg_index == CFG_COMFORT_LIMIT)
          limit_q = cfg_data[7:0];
      end
      if (s_tvalid && s_tready) begin
        advance_flasher(s_tdata[2:0], predicted);
        lamp_forecast.push_back(predicted);
      end
      if (m_tvalid && m_tready) begin
        if (lamp_forecast.size() == 0) begin
          mismatches++;
          $display("%0t: lamp beat with none expected, expected nothing, actual %b",
                   $time, m_tdata[3:0]);
        end else begin
          want = lamp_forecast.pop_front();
          check_lamp("lamp_front_left", want[0], m_tdata[0]);
          check_lamp("lamp_rear_left", want[1], m_tdata[1]);
          check_lamp("lamp_front_right", want[2], m_tdata[2]);
          check_lamp("lamp_rear_right", want[3], m_tdata[3]);
        end
      end
    end
    outstanding <= lamp_forecast.size();
  end

endmodule

// ----- bench/turn_signal_hazard_flasher_tb.sv -----
`timescale 1ns / 1ps

module turn_signal_hazard_flasher_tb
  import tshf_pkg::*;
();

  // Switch bits as they sit in the low end of s_tdata.
  localparam logic [2:0] SW_NONE   = 3'b000;
  localparam logic [2:0] SW_HAZARD = 3'b001;
  localparam logic [2:0] SW_LEFT   = 3'b010;
  localparam logic [2:0] SW_RIGHT  = 3'b100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;    // [0] hazard_switch, [1] left_switch, [2] right_switch
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [0] front left, [1] rear left, [2] front right,
                                  // [3] rear right
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'd0;
  logic [15:0] cfg_data = 16'd0;

  int mismatches;
  int outstanding;

  // Percent chance per cycle that the sender holds back a beat, and that the
  // lamp side refuses one.
  int gap_pct   = 0;
  int stall_pct = 0;

  // Random phases: half period, raw comfort limit write data (only the low byte
  // counts, so the upper bits exercise the truncation) and number of switch beats.
  // Most phases use tiny half periods so that flashing and comfort-off really
  // toggle within a few hundred ticks; one phase uses the largest period.
  logic [15:0] phase_period[8] = '{16'd0, 16'd1, 16'd3, 16'd0,
                                   16'd65535, 16'd2, 16'd7, 16'd1};
  logic [15:0] phase_limit[8]  = '{16'hFF01, 16'h00FF, 16'h0000, 16'hFFFF,
                                   16'h0001, 16'h0003, 16'hA502, 16'h0000};
  int          phase_beats[8]  = '{200, 200, 200, 200, 80, 200, 200, 200};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  turn_signal_hazard_flasher dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  flasher_lamp_checker lamp_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The lamp side decides afresh every cycle whether it takes a beat.
  always @(posedge clk) begin
    m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Four pressure settings: none, sender gaps, receiver stalls, and both.
  task automatic set_pressure(input int sel);
    case (sel)
      1: begin gap_pct = 48; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 48; end
      3: begin gap_pct = 29; stall_pct = 29; end
      default: begin gap_pct = 0; stall_pct = 0; end
    endcase
  endtask

  // Offers one switch beat, possibly after some idle cycles, and returns at the
  // edge where it is taken. Valid stays high into the next beat when no gap is
  // drawn, so back-to-back beats get through.
  task automatic send_switches(input logic [2:0] sw);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, sw};
    do @(posedge clk); while (!s_tready);
  endtask

  // Leaves valid high on return; the caller lowers it after its last write.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Both registers, optionally preceded by writes to indexes past the register
  // list, which the block must ignore.
  task automatic set_flasher(input logic [15:0] period, input logic [15:0] limit,
                             input bit poke_unused);
    if (poke_unused) begin
      write_reg(8'd2, 16'h0001);
      write_reg(8'hFF, 16'hFFFF);
    end
    write_reg(CFG_HALF_PERIOD, period);
    write_reg(CFG_COMFORT_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // Stops sending and waits until every lamp beat predicted so far has come
  // back, plus a margin for the output register.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random switch traffic. Mostly a switch pattern is held for a random stretch
  // of up to several toggles, and a release for up to the time the comfort-off
  // flashing needs to run to its limit, both capped. The rest is short bursts of
  // arbitrary switch combinations, including the overlapping ones. A stretch
  // is cut short so that the phase sends exactly its number of beats.
  task automatic switch_traffic(input int beats, input logic [15:0] period,
                                input logic [7:0] limit);
    int         sent;
    int         pick;
    int         hold;
    int         span;
    logic [2:0] pattern;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        hold = $urandom_range(1, 4);
        if (hold > beats - sent) hold = beats - sent;
        repeat (hold) begin
          send_switches(3'($urandom_range(7)));
          sent++;
        end
      end else begin
        pick = $urandom_range(99);
        if (pick < 30)      pattern = SW_NONE;
        else if (pick < 50) pattern = SW_LEFT;
        else if (pick < 70) pattern = SW_RIGHT;
        else if (pick < 85) pattern = SW_HAZARD;
        else                pattern = 3'($urandom_range(7));
        if (pattern == SW_NONE) begin
          span = (int'(period) + 1) * (int'(limit) + 3);
          if (span > 300) span = 300;
        end else begin
          span = (int'(period) + 1) * 6;
          if (span > 60) span = 60;
        end
        hold = $urandom_range(1, span);
        if (hold > beats - sent) hold = beats - sent;
        repeat (hold) begin
          send_switches(pattern);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: the hazard lights up on its first
    // tick, and a side switch moves the machine into side-on mode.
    set_pressure(0);
    send_switches(SW_NONE);
    send_switches(SW_HAZARD);
    send_switches(SW_HAZARD);
    send_switches(SW_NONE);
    send_switches(SW_LEFT);
    send_switches(SW_NONE);
    drain();

    // Directed part with a short period so that every mode toggles: hazard
    // flashing, a side switch change while the side is already on (ignored),
    // comfort-off after release, re-entry from comfort-off, and hazard taking
    // over with every switch on.
    set_flasher(16'd1, 16'd2, 1'b0);
    send_switches(SW_HAZARD);
    send_switches(SW_HAZARD);
    send_switches(SW_HAZARD);
    send_switches(SW_LEFT);
    send_switches(SW_LEFT);
    send_switches(SW_RIGHT);
    send_switches(SW_RIGHT);
    repeat (4) send_switches(SW_NONE);
    send_switches(SW_RIGHT);
    send_switches(SW_LEFT | SW_RIGHT);
    send_switches(SW_HAZARD | SW_LEFT | SW_RIGHT);
    send_switches(SW_NONE);

    for (int p = 0; p < 8; p++) begin
      drain();
      set_pressure(p % 4);
      set_flasher(phase_period[p], phase_limit[p], (p == 0) || (p == 4));
      switch_traffic(phase_beats[p], phase_period[p], phase_limit[p][7:0]);
    end

    // Back to the reset values, which restores the default comfort behavior.
    drain();
    set_pressure(3);
    set_flasher(HALF_PERIOD_RESET, {8'd0, COMFORT_LIMIT_RESET}, 1'b0);
    switch_traffic(40, HALF_PERIOD_RESET, COMFORT_LIMIT_RESET);

    set_pressure(0);
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Generous ceiling; a correct run with full gaps and stalls needs far less.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tshf_pkg.sv
rtl/turn_signal_hazard_flasher.sv
bench/flasher_lamp_checker.sv
bench/turn_signal_hazard_flasher_tb.sv
